// ===== rtl/fpeau_pkg.sv =====
package fpeau_pkg;

	localparam logic [31:0] CANON_NAN  = 32'h7FC0_0000;
	localparam logic [31:0] POS_INF    = 32'h7F80_0000;
	localparam int          DIV_STAGES = 26;
	localparam int          DLY_STAGES = DIV_STAGES - 4;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MIN = 3'd4,
		OP_MAX = 3'd5
	} op_t;

	// control tag that rides along the pipeline
	typedef struct packed {
		logic               vld;
		logic               spec;
		logic [31:0]        sval;
		logic [2:0]         op;
		logic               sign;
		logic signed [10:0] ex;
	} tag_t;

	// unrounded result: leading one at man[26], sticky folded into man[0]
	typedef struct packed {
		logic               sign;
		logic signed [10:0] ex;
		logic [26:0]        man;
	} ufp_t;

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		logic       hit;
		n   = '0;
		hit = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!hit) begin
				if (v[i]) hit = 1'b1;
				else n = n + 5'd1;
			end
		end
		return n;
	endfunction

	function automatic logic [4:0] lzc28(input logic [27:0] v);
		logic [4:0] n;
		logic       hit;
		n   = '0;
		hit = 1'b0;
		for (int i = 27; i >= 0; i--) begin
			if (!hit) begin
				if (v[i]) hit = 1'b1;
				else n = n + 5'd1;
			end
		end
		return n;
	endfunction

endpackage

// ===== rtl/fpeau_if.sv =====
interface fpeau_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] left_operand;
	logic [31:0] right_operand;

	modport source (output valid, left_operand, right_operand, input ready);
	modport sink (input valid, left_operand, right_operand, output ready);
endinterface

interface fpeau_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_value;

	modport source (output valid, result_value, input ready);
	modport sink (input valid, result_value, output ready);
endinterface

// ===== rtl/fpeau_div.sv =====
module fpeau_div
	import fpeau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  tag_t        tag_in,
	input  logic [24:0] rem_in,
	input  logic [23:0] dvs_in,
	output tag_t        tag_out,
	output logic [26:0] man_out
);

	tag_t        tag_s [DIV_STAGES];
	logic [24:0] rem_s [DIV_STAGES];
	logic [25:0] quo_s [DIV_STAGES];
	logic [23:0] dvs_s [DIV_STAGES];

	// one restoring quotient bit per stage
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stg
		logic [24:0] r_in;
		logic [25:0] q_in;
		logic [23:0] d_in;
		tag_t        t_in;
		logic        ge;
		logic [24:0] diff;

		if (k == 0) begin : g_first
			assign r_in = rem_in;
			assign q_in = '0;
			assign d_in = dvs_in;
			assign t_in = tag_in;
		end else begin : g_next
			assign r_in = rem_s[k-1];
			assign q_in = quo_s[k-1];
			assign d_in = dvs_s[k-1];
			assign t_in = tag_s[k-1];
		end

		assign ge   = r_in >= {1'b0, d_in};
		assign diff = ge ? (r_in - {1'b0, d_in}) : r_in;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_s[k] <= '0;
			end else if (en) begin
				tag_s[k] <= t_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= {diff[23:0], 1'b0};
				quo_s[k] <= {q_in[24:0], ge};
				dvs_s[k] <= d_in;
			end
		end
	end

	assign tag_out = tag_s[DIV_STAGES-1];
	assign man_out = {quo_s[DIV_STAGES-1], |rem_s[DIV_STAGES-1]};

endmodule

// ===== rtl/fp32_elementwise_arith_unit_top.sv =====
// Elementwise binary32 add / subtract / multiply / divide / min / max.
// in_ch carries left_operand and right_operand; out_ch carries result_value,
// one result per input transfer, in order. Both are valid/ready channels.
// The operation register sits at APB address 0 (3 bits). The user must
// write it only while the pipeline is empty; the block does not enforce
// this. It applies to every following transfer. One transfer is accepted
// per cycle while out_ch is not stalled. The depth is set by the divider:
// 26 stages, one quotient bit each, plus three decode/normalize stages and
// two for subnormal shift and rounding. Add and multiply run in a short
// side path and wait in a delay line to meet the divider output.
// Reset clears all valid bits and sets the operation to add.
// When out_ch stalls, the whole pipeline holds: in_ch.ready drops as soon
// as the output register is full and not taken, and nothing is dropped.
// Rounding is to nearest even, subnormals are handled in full and every
// arithmetic NaN comes out as 0x7FC00000.
module fp32_elementwise_arith_unit_top
	import fpeau_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	fpeau_in_if.sink    in_ch,
	fpeau_out_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0] op_q;
	logic       en;

	// config port
	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {29'd0, op_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_ADD;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			op_q <= pwdata[2:0];
		end
	end

	function automatic logic [31:0] okey(input logic [31:0] x);
		return x[31] ? ~x : {1'b1, x[30:0]};
	endfunction

	// ---------------- s1: decode ----------------
	logic [31:0] a, b;
	logic        sa, sb;
	logic        anan, bnan, ainf, binf, azero, bzero;
	logic        spec;
	logic [31:0] sval;
	logic [23:0] ma, mb;
	logic        sx;

	assign a     = in_ch.left_operand;
	assign b     = in_ch.right_operand;
	assign sa    = a[31];
	assign sb    = b[31] ^ (op_q == OP_SUB);
	assign sx    = a[31] ^ b[31];
	assign anan  = (a[30:23] == 8'hFF) && (a[22:0] != '0);
	assign bnan  = (b[30:23] == 8'hFF) && (b[22:0] != '0);
	assign ainf  = (a[30:23] == 8'hFF) && (a[22:0] == '0);
	assign binf  = (b[30:23] == 8'hFF) && (b[22:0] == '0);
	assign azero = a[30:0] == '0;
	assign bzero = b[30:0] == '0;
	assign ma    = {a[30:23] != '0, a[22:0]};
	assign mb    = {b[30:23] != '0, b[22:0]};

	always_comb begin
		spec = 1'b1;
		sval = '0;
		case (op_q)
			OP_ADD, OP_SUB: begin
				if (anan || bnan) sval = CANON_NAN;
				else if (ainf && binf) sval = (sa != sb) ? CANON_NAN : {sa, POS_INF[30:0]};
				else if (ainf) sval = {sa, POS_INF[30:0]};
				else if (binf) sval = {sb, POS_INF[30:0]};
				else if (azero && bzero) sval = {sa & sb, 31'd0};
				else if (azero) sval = {sb, b[30:0]};
				else if (bzero) sval = a;
				else spec = 1'b0;
			end
			OP_MUL: begin
				if (anan || bnan) sval = CANON_NAN;
				else if ((ainf && bzero) || (azero && binf)) sval = CANON_NAN;
				else if (ainf || binf) sval = {sx, POS_INF[30:0]};
				else if (azero || bzero) sval = {sx, 31'd0};
				else spec = 1'b0;
			end
			OP_DIV: begin
				if (anan || bnan) sval = CANON_NAN;
				else if ((ainf && binf) || (azero && bzero)) sval = CANON_NAN;
				else if (ainf || bzero) sval = {sx, POS_INF[30:0]};
				else if (azero || binf) sval = {sx, 31'd0};
				else spec = 1'b0;
			end
			OP_MIN: begin
				if (anan && bnan) sval = CANON_NAN;
				else if (anan) sval = b;
				else if (bnan) sval = a;
				else sval = (okey(a) <= okey(b)) ? a : b;
			end
			OP_MAX: begin
				if (anan && bnan) sval = CANON_NAN;
				else if (anan) sval = b;
				else if (bnan) sval = a;
				else sval = (okey(a) >= okey(b)) ? a : b;
			end
			default: sval = '0;
		endcase
	end

	tag_t               tag_s1, tag_s2, tag_s3;
	logic [23:0]        ma_s1, mb_s1, ma_s2, mb_s2;
	logic signed [9:0]  ea_s1, eb_s1, ea_s2, eb_s2;
	logic               sa_s1, sb_s1, sa_s2, sb_s2;
	logic [4:0]         lza_s1, lzb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (en) begin
			tag_s1 <= '{vld: in_ch.valid, spec: spec, sval: sval, op: op_q,
				sign: 1'b0, ex: 11'sd0};
			tag_s2 <= tag_s1;
			tag_s3 <= '{vld: tag_s2.vld, spec: tag_s2.spec, sval: tag_s2.sval,
				op: tag_s2.op, sign: sa_s2 ^ sb_s2,
				ex: $signed({ea_s2[9], ea_s2}) - $signed({eb_s2[9], eb_s2})
				+ 11'sd127 - ((ma_s2 < mb_s2) ? 11'sd1 : 11'sd0)};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= ma;
			mb_s1  <= mb;
			ea_s1  <= (a[30:23] == '0) ? 10'sd1 : $signed({2'b00, a[30:23]});
			eb_s1  <= (b[30:23] == '0) ? 10'sd1 : $signed({2'b00, b[30:23]});
			sa_s1  <= sa;
			sb_s1  <= sb;
			lza_s1 <= lzc24(ma);
			lzb_s1 <= lzc24(mb);
		end
	end

	// ---------------- s2: normalize operands ----------------
	always_ff @(posedge clk) begin
		if (en) begin
			ma_s2 <= ma_s1 << lza_s1;
			mb_s2 <= mb_s1 << lzb_s1;
			ea_s2 <= ea_s1 - $signed({5'd0, lza_s1});
			eb_s2 <= eb_s1 - $signed({5'd0, lzb_s1});
			sa_s2 <= sa_s1;
			sb_s2 <= sb_s1;
		end
	end

	// ---------------- s3: compare / multiply / divide setup ----------------
	logic              a_ge;
	logic [9:0]        ediff;
	logic [2:0]        op_s3, op_s4, op_s5, op_s6;
	logic [23:0]       mbig_s3, msml_s3, mbig_s4;
	logic [4:0]        shamt_s3;
	logic              effsub_s3, effsub_s4;
	logic signed [9:0] ebig_s3, ebig_s4, ebig_s5, ebig_s6;
	logic              bsign_s3, msign_s3;
	logic [47:0]       prod_s3;
	logic signed [10:0] mex_s3;
	logic [24:0]       rem_s3;
	logic [23:0]       dvs_s3;

	assign a_ge  = (ea_s2 > eb_s2) || ((ea_s2 == eb_s2) && (ma_s2 >= mb_s2));
	assign ediff = a_ge ? 10'(ea_s2 - eb_s2) : 10'(eb_s2 - ea_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3     <= tag_s2.op;
			mbig_s3   <= a_ge ? ma_s2 : mb_s2;
			msml_s3   <= a_ge ? mb_s2 : ma_s2;
			ebig_s3   <= a_ge ? ea_s2 : eb_s2;
			bsign_s3  <= a_ge ? sa_s2 : sb_s2;
			shamt_s3  <= (ediff > 10'd31) ? 5'd31 : ediff[4:0];
			effsub_s3 <= sa_s2 ^ sb_s2;
			prod_s3   <= ma_s2 * mb_s2;
			msign_s3  <= sa_s2 ^ sb_s2;
			mex_s3    <= $signed({ea_s2[9], ea_s2}) + $signed({eb_s2[9], eb_s2})
				- 11'sd127;
			rem_s3    <= (ma_s2 < mb_s2) ? {ma_s2, 1'b0} : {1'b0, ma_s2};
			dvs_s3    <= mb_s2;
		end
	end

	// ---------------- divider: s4..s29 ----------------
	tag_t        tag_d;
	logic [26:0] man_d;

	fpeau_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.tag_in  (tag_s3),
		.rem_in  (rem_s3),
		.dvs_in  (dvs_s3),
		.tag_out (tag_d),
		.man_out (man_d)
	);

	// ---------------- add / multiply side path: s4..s7 ----------------
	logic [57:0] aln_w;
	ufp_t        mul_s4, mul_s5, mul_s6;
	logic        asign_s4, asign_s5, asign_s6;
	logic [26:0] aln_s4;
	logic [27:0] sum_s5, sum_s6;
	logic [4:0]  lz_s6;
	logic [27:0] nrm;
	ufp_t        res_s7;

	assign aln_w = {msml_s3, 3'b000, 31'd0} >> shamt_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4     <= op_s3;
			mbig_s4   <= mbig_s3;
			ebig_s4   <= ebig_s3;
			asign_s4  <= bsign_s3;
			effsub_s4 <= effsub_s3;
			aln_s4    <= {aln_w[57:32], aln_w[31] | (|aln_w[30:0])};
			mul_s4.sign <= msign_s3;
			if (prod_s3[47]) begin
				mul_s4.ex  <= mex_s3 + 11'sd1;
				mul_s4.man <= {prod_s3[47:22], |prod_s3[21:0]};
			end else begin
				mul_s4.ex  <= mex_s3;
				mul_s4.man <= {prod_s3[46:21], |prod_s3[20:0]};
			end

			op_s5    <= op_s4;
			ebig_s5  <= ebig_s4;
			asign_s5 <= asign_s4;
			mul_s5   <= mul_s4;
			sum_s5   <= effsub_s4 ? ({1'b0, mbig_s4, 3'b000} - {1'b0, aln_s4})
				: ({1'b0, mbig_s4, 3'b000} + {1'b0, aln_s4});

			op_s6    <= op_s5;
			ebig_s6  <= ebig_s5;
			asign_s6 <= asign_s5;
			mul_s6   <= mul_s5;
			sum_s6   <= sum_s5;
			lz_s6    <= lzc28(sum_s5);
		end
	end

	assign nrm = sum_s6 << lz_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			if (op_s6 == OP_MUL) begin
				res_s7 <= mul_s6;
			end else if (sum_s6 == '0) begin
				res_s7 <= '{sign: 1'b0, ex: 11'sd0, man: 27'd0};
			end else begin
				res_s7.sign <= asign_s6;
				res_s7.ex   <= $signed({ebig_s6[9], ebig_s6}) + 11'sd1
					- $signed({6'd0, lz_s6});
				res_s7.man  <= {nrm[27:2], |nrm[1:0]};
			end
		end
	end

	// delay line to meet the divider output
	ufp_t res_dly_s [DLY_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			res_dly_s[0] <= res_s7;
			for (int j = 1; j < DLY_STAGES; j++) begin
				res_dly_s[j] <= res_dly_s[j-1];
			end
		end
	end

	// ---------------- s30: merge, subnormal shift ----------------
	ufp_t               mrg;
	logic signed [10:0] shv;
	logic [4:0]         sh;
	logic [57:0]        dn_w;
	tag_t               tag_s30;
	ufp_t               u_s30;

	assign mrg  = (tag_d.op == OP_DIV)
		? ufp_t'{sign: tag_d.sign, ex: tag_d.ex, man: man_d}
		: res_dly_s[DLY_STAGES-1];
	assign shv  = 11'sd1 - mrg.ex;
	assign sh   = (shv > 11'sd31) ? 5'd31 : shv[4:0];
	assign dn_w = {mrg.man, 31'd0} >> sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s30 <= '0;
		end else if (en) begin
			tag_s30 <= tag_d;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s30.sign <= mrg.sign;
			if (mrg.ex < 11'sd1) begin
				u_s30.ex  <= 11'sd0;
				u_s30.man <= {dn_w[57:32], dn_w[31] | (|dn_w[30:0])};
			end else begin
				u_s30.ex  <= mrg.ex;
				u_s30.man <= mrg.man;
			end
		end
	end

	// ---------------- s31: round, output register ----------------
	logic               inc;
	logic [24:0]        rnd;
	logic signed [10:0] ex_r;
	logic [31:0]        rres;
	logic               vld_s31;
	logic [31:0]        res_s31;

	assign inc  = u_s30.man[2] & ((|u_s30.man[1:0]) | u_s30.man[3]);
	assign rnd  = {1'b0, u_s30.man[26:3]} + {24'd0, inc};
	assign ex_r = u_s30.ex + $signed({10'd0, rnd[24]});

	always_comb begin
		if (u_s30.ex == 11'sd0) rres = {u_s30.sign, 7'd0, rnd[23], rnd[22:0]};
		else if (ex_r >= 11'sd255) rres = {u_s30.sign, POS_INF[30:0]};
		else rres = {u_s30.sign, ex_r[7:0], rnd[22:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s31 <= 1'b0;
		end else if (en) begin
			vld_s31 <= tag_s30.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s31 <= tag_s30.spec ? tag_s30.sval : rres;
		end
	end

	assign en                  = !vld_s31 || out_ch.ready;
	assign in_ch.ready         = en;
	assign out_ch.valid        = vld_s31;
	assign out_ch.result_value = res_s31;

endmodule

// ===== rtl/fpeau_checker.sv =====
module fpeau_checker
	import fpeau_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] result_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value))
		else $error("stalled result changed");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input refused with empty output");

	a_ready_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |-> in_ready)
		else $error("input refused while output drains");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input refused without output stall");

	a_nan_canon: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (result_value[30:23] == 8'hFF) && (result_value[22:0] != '0)
		|-> result_value == CANON_NAN)
		else $error("noncanonical NaN");

endmodule

bind fp32_elementwise_arith_unit_top fpeau_checker u_fpeau_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.result_value (out_ch.result_value)
);
